/* rtl/bblf_pkg.sv */
`timescale 1ns / 1ps

package bblf_pkg;

    // Input command kinds
    localparam logic [1:0] KIND_PUSH   = 2'd0;
    localparam logic [1:0] KIND_DUMP   = 2'd1;
    localparam logic [1:0] KIND_RESIZE = 2'd2;

    // Reply kinds
    localparam logic [1:0] RK_PUSH_ACK   = 2'd0;
    localparam logic [1:0] RK_DUMP_ENTRY = 2'd1;
    localparam logic [1:0] RK_RESIZE_ACK = 2'd2;
    localparam logic [1:0] RK_DUMP_EMPTY = 2'd3;

    // Saturation level of the held byte total
    localparam logic [24:0] HELD_MAX = 25'h1FF_FFFF;

    // One stored descriptor
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] code;
        logic [23:0] bytes;
    } desc_t;

    // Commands from the sequencer to the descriptor ring
    typedef struct packed {
        logic rd_head;    // read the oldest descriptor
        logic rd_dump;    // read at the dump pointer and advance it
        logic drop;       // retire the oldest descriptor (read data valid)
        logic append;     // write a new descriptor at the tail
        logic dump_load;  // start the dump pointer at the head
    } ring_cmd_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REPLY,
        ST_P_CHECK,
        ST_P_DROP,
        ST_P_APPEND,
        ST_R_CHECK,
        ST_R_DROP,
        ST_D_READ,
        ST_D_EMIT
    } state_t;

endpackage

/* rtl/bblf_ring.sv */
`timescale 1ns / 1ps

module bblf_ring
    import bblf_pkg::*;
#(
    parameter int DEPTH          = 64,
    parameter int ENTRY_OVERHEAD = 32,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  ring_cmd_t     cmd,
    input  logic [23:0]   app_bytes,
    input  logic [31:0]   app_code,
    input  logic [31:0]   app_id,
    output logic [CW-1:0] count,
    output logic [24:0]   total,
    output logic [24:0]   total_app,
    output logic [6:0]    drop_n,
    output logic [23:0]   rd_bytes,
    output logic [31:0]   rd_code,
    output logic [31:0]   rd_id
);

    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

    desc_t         mem [DEPTH];
    desc_t         rd_q;
    desc_t         wr_desc;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] dptr_reg, dptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [24:0]   total_reg, total_next;

    logic [PW-1:0] head_inc;
    logic [PW-1:0] dptr_inc;
    logic [PW:0]   tail_sum;
    logic [PW-1:0] tail_slot;
    logic [PW-1:0] rd_addr;
    logic          rd_en;
    logic [24:0]   drop_charge;
    logic          drop_clear;
    logic [25:0]   app_sum;

    // Ring pointer arithmetic
    assign head_inc  = (head_reg == LAST_SLOT) ? '0 : head_reg + PW'(1);
    assign dptr_inc  = (dptr_reg == LAST_SLOT) ? '0 : dptr_reg + PW'(1);
    assign tail_sum  = (PW + 1)'(head_reg) + (PW + 1)'(count_reg);
    assign tail_slot = (tail_sum >= (PW + 1)'(DEPTH)) ? PW'(tail_sum - (PW + 1)'(DEPTH))
                                                      : tail_sum[PW-1:0];

    // Charge of the oldest entry; clear the store when it exceeds the total
    assign drop_charge = 25'(rd_q.bytes) + 25'(ENTRY_OVERHEAD);
    assign drop_clear  = drop_charge > total_reg;
    assign drop_n      = drop_clear ? 7'(count_reg) : 7'd1;

    // Saturating total after an append
    assign app_sum   = 26'(total_reg) + 26'(app_bytes) + 26'(ENTRY_OVERHEAD);
    assign total_app = app_sum[25] ? HELD_MAX : app_sum[24:0];

    assign rd_en   = cmd.rd_head | cmd.rd_dump;
    assign rd_addr = cmd.rd_dump ? dptr_reg : head_reg;

    assign wr_desc.id    = app_id;
    assign wr_desc.code  = app_code;
    assign wr_desc.bytes = app_bytes;

    // Next ring state
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        total_next = total_reg;
        dptr_next  = dptr_reg;
        if (cmd.drop)
        begin
            if (drop_clear)
            begin
                count_next = '0;
                total_next = '0;
            end
            else
            begin
                head_next  = head_inc;
                count_next = count_reg - CW'(1);
                total_next = total_reg - drop_charge;
            end
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CW'(1);
            total_next = total_app;
        end
        if (cmd.dump_load)
        begin
            dptr_next = head_reg;
        end
        else if (cmd.rd_dump)
        begin
            dptr_next = dptr_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            total_reg <= '0;
            dptr_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            total_reg <= total_next;
            dptr_reg  <= dptr_next;
        end
    end

    // Descriptor memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[tail_slot] <= wr_desc;
        end
        if (rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    assign count    = count_reg;
    assign total    = total_reg;
    assign rd_bytes = rd_q.bytes;
    assign rd_code  = rd_q.code;
    assign rd_id    = rd_q.id;

endmodule

/* rtl/byte_budget_log_fifo.sv */
`timescale 1ns / 1ps

// Log descriptor FIFO kept under a byte budget. Each held entry costs its
// payload bytes plus ENTRY_OVERHEAD; a push evicts the oldest entries until
// the new one fits (and one more if the ring of DEPTH slots is full), a resize
// evicts until the held bytes fit the new budget, and a dump streams the held
// entries oldest first, stopping after the entry that takes the sent bytes
// past a non-negative amount, with tlast on the final one. Descriptors live
// in one memory with a registered read, and every eviction step or dumped
// entry is a read state followed by a use state. An eviction step drops one
// entry, or the whole store at once when the oldest charge exceeds the held
// total. A stalled reply side holds the walk at each reply word. A new
// command is taken only when the previous one has finished its walk; its last
// reply word may still wait in the output register.

module byte_budget_log_fifo
    import bblf_pkg::*;
#(
    parameter int DEPTH          = 64,
    parameter int ENTRY_OVERHEAD = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,   // amount[24:0], event_code[56:25], zero pad
    input  logic [1:0]   s_axis_tuser,   // kind[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // entry_id[31:0], entry_code[63:32],
                                         // entry_bytes[87:64], evicted[94:88],
                                         // accepted[95], held_bytes[120:96], zero pad
    output logic [1:0]   m_axis_tuser,   // reply_kind[1:0]
    output logic         m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);

    state_t        state_reg, state_next;
    ring_cmd_t     cmd;

    logic [1:0]    kind_reg, kind_next;
    logic [24:0]   amount_reg, amount_next;
    logic [31:0]   code_reg, code_next;
    logic [6:0]    ev_reg, ev_next;
    logic [24:0]   sent_reg, sent_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [23:0]   budget_reg, budget_next;
    logic [31:0]   next_id_reg, next_id_next;

    logic          m_valid_reg, m_valid_next;
    logic [127:0]  m_data_reg, m_data_next;
    logic [1:0]    m_user_reg, m_user_next;
    logic          m_last_reg, m_last_next;

    logic [CW-1:0] count;
    logic [24:0]   total;
    logic [24:0]   total_app;
    logic [6:0]    drop_n;
    logic [23:0]   rd_bytes;
    logic [31:0]   rd_code;
    logic [31:0]   rd_id;

    logic signed [24:0] in_amount;
    logic [1:0]    in_kind;
    logic [31:0]   in_code;
    logic          accept;
    logic          out_free;
    logic          push_skip;
    logic          dump_skip;
    logic          rsz_skip;
    logic [24:0]   push_charge;
    logic          push_over;
    logic          ring_full;
    logic          rsz_over;
    logic [24:0]   dump_sum;
    logic          dump_stop;

    logic          emit;
    logic [1:0]    o_kind;
    logic [31:0]   o_id;
    logic [31:0]   o_code;
    logic [23:0]   o_bytes;
    logic [6:0]    o_ev;
    logic          o_acc;
    logic [24:0]   o_held;
    logic          o_last;

    bblf_ring #(
        .DEPTH          (DEPTH),
        .ENTRY_OVERHEAD (ENTRY_OVERHEAD)
    ) u_ring (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .app_bytes (amount_reg[23:0]),
        .app_code  (code_reg),
        .app_id    (next_id_reg),
        .count     (count),
        .total     (total),
        .total_app (total_app),
        .drop_n    (drop_n),
        .rd_bytes  (rd_bytes),
        .rd_code   (rd_code),
        .rd_id     (rd_id)
    );

    // Unpack the input word
    assign in_kind   = s_axis_tuser;
    assign in_amount = s_axis_tdata[24:0];
    assign in_code   = s_axis_tdata[56:25];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    // Decisions taken at accept
    assign push_skip = (budget_reg == '0) || (in_amount <= 25'sd0);
    assign dump_skip = (in_amount == 25'sd0) || (count == '0);
    assign rsz_skip  = in_amount[24] || (in_amount[23:0] == budget_reg);

    // Eviction loop tests
    assign push_charge = 25'(amount_reg[23:0]) + 25'(ENTRY_OVERHEAD);
    assign push_over   = (26'(total) + 26'(push_charge)) > 26'(budget_reg);
    assign ring_full   = (count == CW'(DEPTH));
    assign rsz_over    = total > amount_reg;

    // Dump stop test
    assign dump_sum  = sent_reg + 25'(rd_bytes);
    assign dump_stop = (!amount_reg[24] && (dump_sum > amount_reg))
                       || ((idx_reg + CW'(1)) == count);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_kind)
                        KIND_PUSH:   state_next = push_skip ? ST_REPLY : ST_P_CHECK;
                        KIND_DUMP:   state_next = dump_skip ? ST_REPLY : ST_D_READ;
                        KIND_RESIZE: state_next = rsz_skip ? ST_REPLY : ST_R_CHECK;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_P_CHECK:
            begin
                if ((push_over && count != '0) || ring_full)
                begin
                    state_next = ST_P_DROP;
                end
                else
                begin
                    state_next = ST_P_APPEND;
                end
            end
            ST_P_DROP:   state_next = ST_P_CHECK;
            ST_P_APPEND:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_R_CHECK:
            begin
                if (rsz_over && count != '0)
                begin
                    state_next = ST_R_DROP;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_R_DROP:   state_next = ST_R_CHECK;
            ST_D_READ:   state_next = ST_D_EMIT;
            ST_D_EMIT:
            begin
                if (out_free)
                begin
                    state_next = dump_stop ? ST_IDLE : ST_D_READ;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs: ring commands, reply fields and working registers
    always_comb
    begin
        cmd          = '0;
        emit         = 1'b0;
        o_kind       = RK_PUSH_ACK;
        o_id         = '0;
        o_code       = '0;
        o_bytes      = '0;
        o_ev         = '0;
        o_acc        = 1'b0;
        o_held       = total;
        o_last       = 1'b1;
        kind_next    = kind_reg;
        amount_next  = amount_reg;
        code_next    = code_reg;
        ev_next      = ev_reg;
        sent_next    = sent_reg;
        idx_next     = idx_reg;
        budget_next  = budget_reg;
        next_id_next = next_id_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = in_kind;
                    amount_next   = in_amount;
                    code_next     = in_code;
                    ev_next       = '0;
                    sent_next     = '0;
                    idx_next      = '0;
                    cmd.dump_load = (in_kind == KIND_DUMP);
                end
            end
            ST_REPLY:
            begin
                emit = out_free;
                unique case (kind_reg)
                    KIND_DUMP:   o_kind = RK_DUMP_EMPTY;
                    KIND_RESIZE: o_kind = RK_RESIZE_ACK;
                    default:     o_kind = RK_PUSH_ACK;
                endcase
            end
            ST_P_CHECK:
            begin
                cmd.rd_head = (push_over && count != '0) || ring_full;
            end
            ST_R_CHECK:
            begin
                if (rsz_over && count != '0)
                begin
                    cmd.rd_head = 1'b1;
                end
                else
                begin
                    emit   = out_free;
                    o_kind = RK_RESIZE_ACK;
                    o_ev   = ev_reg;
                    o_acc  = 1'b1;
                    if (out_free)
                    begin
                        budget_next = amount_reg[23:0];
                    end
                end
            end
            ST_P_DROP, ST_R_DROP:
            begin
                cmd.drop = 1'b1;
                ev_next  = ev_reg + drop_n;
            end
            ST_P_APPEND:
            begin
                emit       = out_free;
                cmd.append = out_free;
                o_kind     = RK_PUSH_ACK;
                o_id       = next_id_reg;
                o_ev       = ev_reg;
                o_acc      = 1'b1;
                o_held     = total_app;
                if (out_free)
                begin
                    next_id_next = next_id_reg + 32'd1;
                end
            end
            ST_D_READ:
            begin
                cmd.rd_dump = 1'b1;
            end
            ST_D_EMIT:
            begin
                emit    = out_free;
                o_kind  = RK_DUMP_ENTRY;
                o_id    = rd_id;
                o_code  = rd_code;
                o_bytes = rd_bytes;
                o_last  = dump_stop;
                if (out_free)
                begin
                    sent_next = dump_sum;
                    idx_next  = idx_reg + CW'(1);
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Output register: load a reply word, drop it once taken
    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        if (emit)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {7'd0, o_held, o_acc, o_ev, o_bytes, o_code, o_id};
            m_user_next  = o_kind;
            m_last_next  = o_last;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            budget_reg  <= '0;
            next_id_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            budget_reg  <= budget_next;
            next_id_reg <= next_id_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        amount_reg <= amount_next;
        code_reg   <= code_next;
        ev_reg     <= ev_next;
        sent_reg   <= sent_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

/* rtl/bblf_checker.sv */
`timescale 1ns / 1ps

module bblf_checker
    import bblf_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    // A stalled reply word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("reply word changed while stalled");

    // Every reply word other than a dump entry carries tlast, as the only word of its command
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != RK_DUMP_ENTRY) |-> m_axis_tlast)
        else $error("single reply without tlast");

    // Dump words carry no eviction count and no accept flag
    a_dump_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == RK_DUMP_ENTRY || m_axis_tuser == RK_DUMP_EMPTY)
            |-> (m_axis_tdata[94:88] == 7'd0) && !m_axis_tdata[95])
        else $error("dump word with eviction or accept set");

    // A push, dump or resize command closes the input until it is done
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready
            && (s_axis_tuser == KIND_PUSH || s_axis_tuser == KIND_DUMP
                || s_axis_tuser == KIND_RESIZE)
            |=> !s_axis_tready)
        else $error("input taken while a command is in progress");

endmodule

bind byte_budget_log_fifo bblf_checker u_bblf_checker (.*);
